// ===== hdl/sta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scope timing aggregator package
// Shared item types, command codes, status codes and storage entry layouts.
// ----------------------------------------------------------------------------
package sta_pkg;

  // Item modes
  localparam logic [2:0] MODE_BEGIN   = 3'd0;
  localparam logic [2:0] MODE_END     = 3'd1;
  localparam logic [2:0] MODE_QUERY   = 3'd2;
  localparam logic [2:0] MODE_WATCH   = 3'd3;
  localparam logic [2:0] MODE_UNWATCH = 3'd4;
  localparam logic [2:0] MODE_RESET   = 3'd5;

  // Result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_IGNORED   = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;

  // Timer constants
  localparam logic [19:0] NS_PER_MS        = 20'd1000000;
  localparam logic [63:0] THRESHOLD_RESET  = 64'd1000000000;

  // Field widths that do not vary
  localparam int WATCH_W = 7;
  localparam int WIN_W   = 7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] name_hash;
    logic        source;
    logic [63:0] timestamp_ns;
    logic [6:0]  window_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] last_ns;
    logic [63:0] min_ns;
    logic [63:0] max_ns;
    logic [31:0] hit_count;
    logic [63:0] avg_ns;
    logic        stats_were_reset;
  } out_item_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic [2:0]       mode;
    logic [31:0]      key;
    logic [1:0]       src;
    logic [63:0]      ts;
    logic [WIN_W-1:0] wsize;
    logic             key_nz;
  } cmd_t;

  typedef struct packed {
    logic [31:0] key;
    logic [1:0]  src;
    logic [63:0] begin_ns;
  } stack_ent_t;

  typedef struct packed {
    logic [31:0]        key;
    logic [1:0]         src;
    logic [63:0]        last;
    logic [WATCH_W-1:0] watch;
  } slot_id_t;

  typedef struct packed {
    logic [63:0] min;
    logic [63:0] max;
    logic [31:0] hits;
  } slot_stat_t;

endpackage
`default_nettype wire

// ===== hdl/sta_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/sta_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divide of a 64-bit dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sta_div #(
  parameter int DIV_W = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [63:0]      dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [63:0]      quotient,
  output logic      [DIV_W-1:0] remainder
);

  logic [63:0]      dvd;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W-1:0] rem;
  logic [6:0]       cnt;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  assign trial = {rem, dvd[63]};
  assign diff  = trial - {1'b0, dsr};

  // Shift in one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= 7'd64;
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dsr}) begin
          rem <= diff[DIV_W-1:0];
          dvd <= {dvd[62:0], 1'b1};
        end else begin
          rem <= trial[DIV_W-1:0];
          dvd <= {dvd[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== hdl/sta_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Front end
// Accepts items, classifies them into commands and queues them for the back.
// ----------------------------------------------------------------------------
module sta_front
  import sta_pkg::*;
#(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     hold,
  output logic          q_valid,
  input  wire logic     q_pop,
  output cmd_t          q_cmd
);

  cmd_t       qmem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       push;

  // Classify the incoming item
  always_comb begin
    cls.mode   = in_item.mode;
    cls.key    = in_item.name_hash;
    cls.src    = {1'b0, in_item.source} + 2'd1;
    cls.ts     = in_item.timestamp_ns;
    cls.key_nz = (in_item.name_hash != 32'd0);
    if (32'(in_item.window_size) > WINDOW_MAX) begin
      cls.wsize = WIN_W'(WINDOW_MAX);
    end else begin
      cls.wsize = in_item.window_size;
    end
  end

  assign in_ready = (count != 2'd2) && !hold;
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = qmem[rd_ptr];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        qmem[wr_ptr] <= cls;
        wr_ptr       <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sta_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Back end
// Sequencer that runs each command on the scope stack, slot table and windows.
// ----------------------------------------------------------------------------
module sta_back
  import sta_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int STACK_DEPTH   = 64,
  parameter int WATCH_SLOTS   = 16,
  parameter int WINDOW_MAX    = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire cmd_t        q_cmd,
  output logic             init_busy,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item
);

  localparam int TA_W  = $clog2(TABLE_ENTRIES);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int SF_W  = $clog2(STACK_DEPTH + 1);
  localparam int WDEP  = WATCH_SLOTS * WINDOW_MAX;
  localparam int WA_W  = (WDEP > 1) ? $clog2(WDEP) : 1;
  localparam int WI_W  = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
  localparam int DIV_W = WIN_W;

  localparam logic [4:0] S_INIT      = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_START     = 5'd2;
  localparam logic [4:0] S_CLRB      = 5'd3;
  localparam logic [4:0] S_PUSH      = 5'd4;
  localparam logic [4:0] S_SRCH_RD   = 5'd5;
  localparam logic [4:0] S_SRCH_CMP  = 5'd6;
  localparam logic [4:0] S_SHIFT_RD  = 5'd7;
  localparam logic [4:0] S_SHIFT_WR  = 5'd8;
  localparam logic [4:0] S_CHK       = 5'd9;
  localparam logic [4:0] S_HASH      = 5'd10;
  localparam logic [4:0] S_PROBE_RD  = 5'd12;
  localparam logic [4:0] S_PROBE_CMP = 5'd13;
  localparam logic [4:0] S_ACT       = 5'd14;
  localparam logic [4:0] S_SUM_RD    = 5'd15;
  localparam logic [4:0] S_SUM_ACC   = 5'd16;
  localparam logic [4:0] S_AVG       = 5'd17;
  localparam logic [4:0] S_AVG_WAIT  = 5'd18;
  localparam logic [4:0] S_DONE      = 5'd19;

  localparam logic [WATCH_W-1:0] WATCH_NONE = WATCH_W'(WATCH_SLOTS);

  logic [4:0]         state;
  cmd_t               cmd;
  logic [TA_W-1:0]    idx;
  logic [TA_W-1:0]    pc;
  logic [SF_W-1:0]    si;
  logic [SF_W-1:0]    sj;
  logic [SF_W-1:0]    stack_fill;
  logic [63:0]        begin_ns;
  logic [63:0]        dur;
  slot_id_t           ent_a;
  slot_stat_t         ent_b;
  logic [63:0]        sum;
  logic [WIN_W-1:0]   sk;
  logic [WIN_W-1:0]   fcount;
  logic [WI_W-1:0]    wsel_r;
  logic [63:0]        thr;
  logic [63:0]        lrt;
  logic [WATCH_W-1:0] watch_used;
  logic [WIN_W-1:0]   win_head   [WATCH_SLOTS];
  logic [WIN_W-1:0]   win_filled [WATCH_SLOTS];
  logic [WIN_W-1:0]   win_len    [WATCH_SLOTS];

  logic [2:0]  res_status;
  logic [63:0] res_last;
  logic [63:0] res_min;
  logic [63:0] res_max;
  logic [31:0] res_hits;
  logic [63:0] res_avg;
  logic        res_fired;

  // Storage ports
  logic                        a_we;
  slot_id_t                    a_wdata;
  logic [$bits(slot_id_t)-1:0] a_rbits;
  slot_id_t                    rd_a;
  logic                        b_we;
  slot_stat_t                  b_wdata;
  logic [$bits(slot_stat_t)-1:0] b_rbits;
  slot_stat_t                  rd_b;
  logic                        stk_we;
  logic [SA_W-1:0]             stk_waddr;
  stack_ent_t                  stk_wdata;
  logic [SA_W-1:0]             stk_raddr;
  logic [$bits(stack_ent_t)-1:0] stk_rbits;
  stack_ent_t                  rd_stk;
  logic                        win_we;
  logic [WA_W-1:0]             win_waddr;
  logic [WA_W-1:0]             win_raddr;
  logic [63:0]                 win_rdata;
  logic                        div_start;
  logic [63:0]                 div_dividend;
  logic [DIV_W-1:0]            div_divisor;
  logic                        div_done;
  logic [63:0]                 div_quot;
  logic [DIV_W-1:0]            div_rem;

  // Derived values
  logic             match_a;
  logic             match_stk;
  logic             claim;
  logic             tfire;
  logic [4:0]       after_timer;
  logic [WI_W-1:0]  wsel;
  logic             wvalid;
  logic [WIN_W-1:0] cur_head;
  logic [WIN_W-1:0] cur_len;
  logic [WIN_W-1:0] cur_filled;
  logic [WIN_W-1:0] head_next;
  slot_stat_t       rec_b;

  assign rd_a      = slot_id_t'(a_rbits);
  assign rd_b      = slot_stat_t'(b_rbits);
  assign rd_stk    = stack_ent_t'(stk_rbits);
  assign cfg_ready = 1'b1;
  assign init_busy = (state == S_INIT);

  assign match_a   = (rd_a.key == cmd.key) && (rd_a.src == cmd.src);
  assign match_stk = (rd_stk.key == cmd.key) && (rd_stk.src == cmd.src);
  assign claim     = (cmd.mode == MODE_END) || (cmd.mode == MODE_WATCH);
  assign tfire     = (thr != 64'd0) && (lrt != 64'd0) && ((cmd.ts - lrt) >= thr);
  assign after_timer = (cmd.mode == MODE_BEGIN) ? S_PUSH :
                       (cmd.key_nz ? S_SRCH_RD : S_DONE);

  assign wsel       = ent_a.watch[WI_W-1:0];
  assign wvalid     = (ent_a.watch < watch_used);
  assign cur_head   = win_head[wsel];
  assign cur_len    = win_len[wsel];
  assign cur_filled = win_filled[wsel];
  assign head_next  = ((cur_head + WIN_W'(1)) == cur_len) ? '0 : cur_head + WIN_W'(1);

  // Statistics update for a recorded duration
  always_comb begin
    rec_b.min  = (dur < ent_b.min) ? dur : ent_b.min;
    rec_b.max  = (dur > ent_b.max) ? dur : ent_b.max;
    rec_b.hits = ent_b.hits + 32'd1;
  end

  // Drive the storage ports from the sequencer state
  always_comb begin
    a_we         = 1'b0;
    a_wdata      = ent_a;
    b_we         = 1'b0;
    b_wdata      = '{min: '1, max: '0, hits: '0};
    stk_we       = 1'b0;
    stk_waddr    = stack_fill[SA_W-1:0];
    stk_wdata    = '{key: cmd.key, src: cmd.src, begin_ns: cmd.ts};
    stk_raddr    = SA_W'(si - SF_W'(1));
    win_we       = 1'b0;
    win_waddr    = WA_W'(32'(wsel) * WINDOW_MAX + 32'(cur_head));
    win_raddr    = WA_W'(32'(wsel_r) * WINDOW_MAX + 32'(sk));
    div_start    = 1'b0;
    div_dividend = sum;
    div_divisor  = DIV_W'(fcount);
    q_pop        = 1'b0;
    case (state)
      S_INIT: begin
        a_we    = 1'b1;
        a_wdata = '{key: '0, src: '0, last: '0, watch: WATCH_NONE};
        b_we    = 1'b1;
      end
      S_IDLE: begin
        q_pop = q_valid;
      end
      S_CLRB: begin
        b_we = 1'b1;
      end
      S_PUSH: begin
        stk_we = cmd.key_nz && (stack_fill < SF_W'(STACK_DEPTH));
      end
      S_SHIFT_RD: begin
        stk_raddr = SA_W'(sj + SF_W'(1));
      end
      S_SHIFT_WR: begin
        stk_we    = 1'b1;
        stk_waddr = sj[SA_W-1:0];
        stk_wdata = rd_stk;
      end
      S_PROBE_CMP: begin
        if (rd_a.key == 32'd0 && claim) begin
          a_we    = 1'b1;
          a_wdata = '{key: cmd.key, src: cmd.src, last: rd_a.last, watch: rd_a.watch};
        end
      end
      S_ACT: begin
        case (cmd.mode)
          MODE_END: begin
            a_we       = 1'b1;
            a_wdata.last = dur;
            b_we       = 1'b1;
            b_wdata    = rec_b;
            win_we     = wvalid && (cur_len != '0);
          end
          MODE_WATCH: begin
            if (!wvalid && watch_used < WATCH_W'(WATCH_SLOTS)) begin
              a_we          = 1'b1;
              a_wdata.watch = watch_used;
            end
          end
          MODE_UNWATCH: begin
            a_we          = 1'b1;
            a_wdata.watch = WATCH_NONE;
          end
          default: begin
            a_we = 1'b0;
          end
        endcase
      end
      S_AVG: begin
        div_start = 1'b1;
      end
      default: begin
        a_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      idx        <= '0;
      stack_fill <= '0;
      watch_used <= '0;
      lrt        <= '0;
      thr        <= THRESHOLD_RESET;
      out_valid  <= 1'b0;
      for (int w = 0; w < WATCH_SLOTS; w++) begin
        win_head[w]   <= '0;
        win_filled[w] <= '0;
        win_len[w]    <= '0;
      end
    end else begin
      // Hold the threshold in nanoseconds
      if (cfg_valid) begin
        thr <= {12'd0, 52'(cfg_data) * 52'(NS_PER_MS)};
      end
      // Drop the result once taken, unless a new one is loaded now
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          idx <= idx + TA_W'(1);
          if (idx == TA_W'(TABLE_ENTRIES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cmd        <= q_cmd;
            res_status <= STAT_IGNORED;
            res_last   <= '0;
            res_min    <= '0;
            res_max    <= '0;
            res_hits   <= '0;
            res_avg    <= '0;
            res_fired  <= 1'b0;
            state      <= S_START;
          end
        end
        S_START: begin
          si  <= stack_fill;
          idx <= '0;
          case (cmd.mode)
            MODE_BEGIN, MODE_END: begin
              if (tfire) begin
                lrt       <= cmd.ts;
                res_fired <= 1'b1;
                state     <= S_CLRB;
              end else begin
                if (thr != 64'd0 && lrt == 64'd0) begin
                  lrt <= cmd.ts;
                end
                state <= after_timer;
              end
            end
            MODE_QUERY, MODE_UNWATCH: begin
              state <= cmd.key_nz ? S_HASH : S_DONE;
            end
            MODE_WATCH: begin
              state <= (cmd.key_nz && cmd.wsize != '0) ? S_HASH : S_DONE;
            end
            MODE_RESET: begin
              lrt        <= cmd.ts;
              res_status <= STAT_OK;
              state      <= S_CLRB;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_CLRB: begin
          idx <= idx + TA_W'(1);
          if (idx == TA_W'(TABLE_ENTRIES - 1)) begin
            state <= (cmd.mode == MODE_RESET) ? S_DONE : after_timer;
          end
        end
        S_PUSH: begin
          if (cmd.key_nz && stack_fill < SF_W'(STACK_DEPTH)) begin
            stack_fill <= stack_fill + SF_W'(1);
            res_status <= STAT_OK;
          end
          state <= S_DONE;
        end
        S_SRCH_RD: begin
          state <= (si == '0) ? S_DONE : S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (match_stk) begin
            begin_ns <= rd_stk.begin_ns;
            sj       <= si - SF_W'(1);
            state    <= S_SHIFT_RD;
          end else begin
            si    <= si - SF_W'(1);
            state <= S_SRCH_RD;
          end
        end
        S_SHIFT_RD: begin
          if ((sj + SF_W'(1)) < stack_fill) begin
            state <= S_SHIFT_WR;
          end else begin
            stack_fill <= stack_fill - SF_W'(1);
            state      <= S_CHK;
          end
        end
        S_SHIFT_WR: begin
          sj    <= sj + SF_W'(1);
          state <= S_SHIFT_RD;
        end
        S_CHK: begin
          dur   <= cmd.ts - begin_ns;
          state <= (cmd.ts >= begin_ns) ? S_HASH : S_DONE;
        end
        // Home slot is the low key bits; the table size is a power of two
        S_HASH: begin
          idx   <= cmd.key[TA_W-1:0];
          pc    <= '0;
          state <= S_PROBE_RD;
        end
        S_PROBE_RD: begin
          state <= S_PROBE_CMP;
        end
        S_PROBE_CMP: begin
          ent_b <= rd_b;
          if (rd_a.key == 32'd0) begin
            if (claim) begin
              ent_a <= '{key: cmd.key, src: cmd.src, last: rd_a.last, watch: rd_a.watch};
              state <= S_ACT;
            end else begin
              res_status <= STAT_NOT_FOUND;
              state      <= S_DONE;
            end
          end else if (match_a) begin
            ent_a <= rd_a;
            state <= S_ACT;
          end else if (pc == TA_W'(TABLE_ENTRIES - 1)) begin
            res_status <= claim ? STAT_OVERFLOW : STAT_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            pc    <= pc + TA_W'(1);
            idx   <= (idx == TA_W'(TABLE_ENTRIES - 1)) ? '0 : idx + TA_W'(1);
            state <= S_PROBE_RD;
          end
        end
        S_ACT: begin
          case (cmd.mode)
            MODE_END: begin
              res_status <= STAT_OK;
              state      <= S_DONE;
              if (wvalid && cur_len != '0) begin
                win_head[wsel] <= head_next;
                if (cur_filled < cur_len) begin
                  win_filled[wsel] <= cur_filled + WIN_W'(1);
                end
              end
            end
            MODE_QUERY: begin
              res_status <= STAT_OK;
              res_last   <= ent_a.last;
              res_min    <= ent_b.min;
              res_max    <= ent_b.max;
              res_hits   <= ent_b.hits;
              if (wvalid && cur_filled != '0) begin
                sum    <= '0;
                sk     <= '0;
                fcount <= cur_filled;
                wsel_r <= wsel;
                state  <= S_SUM_RD;
              end else begin
                state <= S_DONE;
              end
            end
            MODE_WATCH: begin
              state <= S_DONE;
              if (wvalid) begin
                win_head[wsel]   <= '0;
                win_filled[wsel] <= '0;
                win_len[wsel]    <= cmd.wsize;
                res_status       <= STAT_OK;
              end else if (watch_used < WATCH_W'(WATCH_SLOTS)) begin
                win_head[watch_used[WI_W-1:0]]   <= '0;
                win_filled[watch_used[WI_W-1:0]] <= '0;
                win_len[watch_used[WI_W-1:0]]    <= cmd.wsize;
                watch_used <= watch_used + WATCH_W'(1);
                res_status <= STAT_OK;
              end else begin
                res_status <= STAT_FULL;
              end
            end
            MODE_UNWATCH: begin
              res_status <= STAT_OK;
              state      <= S_DONE;
            end
            default: begin
              res_status <= STAT_IGNORED;
              state      <= S_DONE;
            end
          endcase
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          sum <= sum + win_rdata;
          sk  <= sk + WIN_W'(1);
          state <= ((sk + WIN_W'(1)) == fcount) ? S_AVG : S_SUM_RD;
        end
        S_AVG: begin
          state <= S_AVG_WAIT;
        end
        S_AVG_WAIT: begin
          if (div_done) begin
            res_avg <= div_quot;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item  <= '{status: res_status, last_ns: res_last, min_ns: res_min,
                           max_ns: res_max, hit_count: res_hits, avg_ns: res_avg,
                           stats_were_reset: res_fired};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  sta_ram #(.WIDTH($bits(stack_ent_t)), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rbits)
  );

  sta_ram #(.WIDTH($bits(slot_id_t)), .DEPTH(TABLE_ENTRIES)) u_slot_id (
    .clk   (clk),
    .we    (a_we),
    .waddr (idx),
    .wdata (a_wdata),
    .raddr (idx),
    .rdata (a_rbits)
  );

  sta_ram #(.WIDTH($bits(slot_stat_t)), .DEPTH(TABLE_ENTRIES)) u_slot_stat (
    .clk   (clk),
    .we    (b_we),
    .waddr (idx),
    .wdata (b_wdata),
    .raddr (idx),
    .rdata (b_rbits)
  );

  sta_ram #(.WIDTH(64), .DEPTH(WDEP)) u_window (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (dur),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  sta_div #(.DIV_W(DIV_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stack_fill <= SF_W'(STACK_DEPTH))
    else $error("scope stack fill past depth");

  a_watch_bound: assert property (@(posedge clk) disable iff (rst)
    watch_used <= WATCH_W'(WATCH_SLOTS))
    else $error("watch entries past limit");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && q_valid)
    else $error("queue popped outside idle");

  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (!out_valid || out_ready) |=> out_valid && (state == S_IDLE))
    else $error("finished item not presented");

  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_INIT) |-> !out_valid && !q_pop)
    else $error("activity during clearing pass");

endmodule
`default_nettype wire

// ===== hdl/scope_timing_aggregator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scope timing aggregator
// Pairs begin/end events on a scope stack and keeps per-scope duration stats.
// ----------------------------------------------------------------------------
// An end searches the stack frames, shifts the frames above the match down and
//   probes the table; a query probes it and may sum window samples for the average.
// Throughput: one item at a time in the back sequencer; a two-entry queue and
//   the output register let input and output stall independently.
// Stats reset (item or timer) sweeps the stats memory.
// Reset: synchronous; a clearing pass over the slot table runs before the
//   first item is accepted. Config writes are taken at any time.
module scope_timing_aggregator
  import sta_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024,
  parameter int STACK_DEPTH   = 64,
  parameter int WATCH_SLOTS   = 16,
  parameter int WINDOW_MAX    = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  logic init_busy;

  sta_front #(.WINDOW_MAX(WINDOW_MAX)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .hold     (init_busy),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  sta_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .STACK_DEPTH   (STACK_DEPTH),
    .WATCH_SLOTS   (WATCH_SLOTS),
    .WINDOW_MAX    (WINDOW_MAX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
